[hdl/cttp_pkg.sv]
package cttp_pkg;

    localparam int COORD_BITS       = 12;
    localparam int RADIUS_FRAC_BITS = 4;

    localparam int DIFF_W   = COORD_BITS + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int DET_W    = PROD_W + 1;
    localparam int SQ_W     = 2 * COORD_BITS;
    localparam int SDIF_W   = SQ_W + 1;
    localparam int SIDE_W   = PROD_W;
    localparam int PAIR_W   = 2 * SIDE_W;
    localparam int TRIP_W   = 3 * SIDE_W;
    localparam int CNUM_W   = SDIF_W + DIFF_W + 1;
    localparam int CEN_D_W  = DET_W + 1;
    localparam int RAD_D_W  = 2 * DET_W;
    localparam int RAD_N_W  = TRIP_W + 2 * RADIUS_FRAC_BITS;
    localparam int ROOT_W   = RAD_N_W / 2;
    localparam int SQ_REM_W = ROOT_W + 3;

    localparam int CENTER_W = 41;
    localparam int RADIUS_W = 44;
    localparam int IN_W     = 6 * COORD_BITS;
    localparam int OUT_W    = 128;

    typedef struct packed {
        logic [RAD_N_W-1:0] n;
        logic [RAD_D_W:0]   r;
        logic [RAD_D_W-1:0] d;
    } rad_div_t;

    typedef struct packed {
        logic [RAD_N_W-1:0] n;
        logic [CEN_D_W:0]   r;
        logic [CEN_D_W-1:0] d;
    } cen_div_t;

    typedef struct packed {
        rad_div_t rad;
        cen_div_t cx;
        cen_div_t cy;
        logic     sx;
        logic     sy;
        logic     deg;
    } div_t;

    typedef struct packed {
        logic [RAD_N_W-1:0]  n;
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
        logic [CENTER_W-1:0] qx;
        logic [CENTER_W-1:0] qy;
        logic                sx;
        logic                sy;
        logic                deg;
    } sq_t;

endpackage

[hdl/circle_through_three_points_core.sv]
// Circle through three points, fully pipelined.
// The slave channel takes one point triple per transfer on s_tdata; the
// master channel returns the center, the radius and a collinearity flag.
// A new transfer can be accepted on every clock cycle while the output register is not stalled.
// The pipeline is a front for products and differences, a row of 86 divider
// cells with one quotient bit per cell, a row of 43 square root cells with one
// root bit per cell, and one output register.
// The center coordinates are the exact values truncated toward zero; the
// radius carries four fraction bits and is floored.
// Collinear points give center 0,0, radius 0 and tuser set.
// The whole pipeline advances as one: while the output register holds a
// transfer that the receiver does not take, every stage holds and s_tready
// is low. Reset clears all valid bits, so no transfer appears until the
// first triple has passed through the pipeline.
module circle_through_three_points_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // first_x, first_y, second_x, second_y, third_x, third_y
    input  logic [cttp_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // center_x, center_y, radius, zero fill
    output logic [cttp_pkg::OUT_W-1:0]  m_tdata,
    // degenerate
    output logic                        m_tuser
);
    import cttp_pkg::*;

    localparam int DIV_N = RAD_N_W;
    localparam int SQ_N  = ROOT_W;

    logic adv;
    logic div_v [DIV_N+1];
    div_t div_d [DIV_N+1];
    logic sq_v  [SQ_N+1];
    sq_t  sq_d  [SQ_N+1];

    logic                 m_tvalid_reg;
    logic [OUT_W-1:0]     m_tdata_reg;
    logic                 m_tuser_reg;
    logic [CENTER_W-1:0]  cx_next, cy_next;
    logic [RADIUS_W-1:0]  r_next;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    cttp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_valid (div_v[0]),
        .out_data  (div_d[0])
    );

    genvar gi;
    generate
        for (gi = 0; gi < DIV_N; gi++)
        begin : g_div
            cttp_div_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (adv),
                .in_valid  (div_v[gi]),
                .in_data   (div_d[gi]),
                .out_valid (div_v[gi+1]),
                .out_data  (div_d[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        sq_v[0]      = div_v[DIV_N];
        sq_d[0].n    = div_d[DIV_N].rad.n;
        sq_d[0].rem  = '0;
        sq_d[0].root = '0;
        sq_d[0].qx   = div_d[DIV_N].cx.n[CENTER_W-1:0];
        sq_d[0].qy   = div_d[DIV_N].cy.n[CENTER_W-1:0];
        sq_d[0].sx   = div_d[DIV_N].sx;
        sq_d[0].sy   = div_d[DIV_N].sy;
        sq_d[0].deg  = div_d[DIV_N].deg;
    end

    generate
        for (gi = 0; gi < SQ_N; gi++)
        begin : g_sqrt
            cttp_sqrt_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (adv),
                .in_valid  (sq_v[gi]),
                .in_data   (sq_d[gi]),
                .out_valid (sq_v[gi+1]),
                .out_data  (sq_d[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        if (sq_d[SQ_N].deg)
        begin
            cx_next = '0;
            cy_next = '0;
            r_next  = '0;
        end
        else
        begin
            cx_next = sq_d[SQ_N].sx ? -sq_d[SQ_N].qx : sq_d[SQ_N].qx;
            cy_next = sq_d[SQ_N].sy ? -sq_d[SQ_N].qy : sq_d[SQ_N].qy;
            r_next  = RADIUS_W'(sq_d[SQ_N].root);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_tvalid_reg <= sq_v[SQ_N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_tdata_reg <= OUT_W'({r_next, cy_next, cx_next});
            m_tuser_reg <= sq_d[SQ_N].deg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_degenerate_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("degenerate result carries a nonzero payload");

    a_hold_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("pipeline moved while output stalled");

    a_ready_rule : assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready disagrees with output register state");

endmodule

[hdl/cttp_front.sv]
module cttp_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [cttp_pkg::IN_W-1:0]     in_data,
    output logic                          out_valid,
    output cttp_pkg::div_t                out_data
);
    import cttp_pkg::*;

    logic [5:0] vld_reg;

    logic signed [DIFF_W-1:0] a1_reg, b1_reg, c1_reg, e1_reg, f1_reg, g1_reg;
    logic signed [COORD_BITS-1:0] x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;

    logic signed [PROD_W-1:0] p1_reg, p2_reg;
    logic [SQ_W-1:0]          s1_reg, s2_reg, s3_reg;
    logic [SIDE_W-1:0]        l12_reg, l23_reg, l31_reg;
    logic signed [DIFF_W-1:0] a2_reg, b2_reg, c2_reg, e2_reg;

    logic signed [DET_W-1:0]  det3_reg;
    logic signed [SDIF_W-1:0] d12_reg, d23_reg;
    logic [PAIR_W-1:0]        pp_reg;
    logic [SIDE_W-1:0]        l31b_reg;
    logic signed [DIFF_W-1:0] a3_reg, b3_reg, c3_reg, e3_reg;

    logic signed [CNUM_W-2:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic [RAD_D_W-1:0]       det2_reg;
    logic [PAIR_W-1:0]        ph_reg, pl_reg;
    logic [DET_W-1:0]         adet4_reg;
    logic                     deg4_reg, neg4_reg;

    logic signed [CNUM_W-1:0] nx_reg, ny_reg;
    logic [TRIP_W-1:0]        num_reg;
    logic [RAD_D_W-1:0]       dsq_reg;
    logic [DET_W-1:0]         adet5_reg;
    logic                     deg5_reg, neg5_reg;

    div_t out_reg;

    logic signed [COORD_BITS-1:0] ix1, iy1, ix2, iy2, ix3, iy3;
    logic signed [2*DET_W-1:0]    det_sq;
    logic [CNUM_W-1:0]            anx, any_v;
    logic [DET_W-1:0]             adet_v;

    assign ix1 = in_data[0*COORD_BITS +: COORD_BITS];
    assign iy1 = in_data[1*COORD_BITS +: COORD_BITS];
    assign ix2 = in_data[2*COORD_BITS +: COORD_BITS];
    assign iy2 = in_data[3*COORD_BITS +: COORD_BITS];
    assign ix3 = in_data[4*COORD_BITS +: COORD_BITS];
    assign iy3 = in_data[5*COORD_BITS +: COORD_BITS];

    assign det_sq = det3_reg * det3_reg;
    assign adet_v = det3_reg[DET_W-1] ? DET_W'(-det3_reg) : DET_W'(det3_reg);
    assign anx    = nx_reg[CNUM_W-1] ? CNUM_W'(-nx_reg) : CNUM_W'(nx_reg);
    assign any_v  = ny_reg[CNUM_W-1] ? CNUM_W'(-ny_reg) : CNUM_W'(ny_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg <= ix1;
            y1_reg <= iy1;
            x2_reg <= ix2;
            y2_reg <= iy2;
            x3_reg <= ix3;
            y3_reg <= iy3;
            a1_reg <= DIFF_W'(ix1) - DIFF_W'(ix2);
            b1_reg <= DIFF_W'(iy2) - DIFF_W'(iy3);
            c1_reg <= DIFF_W'(ix2) - DIFF_W'(ix3);
            e1_reg <= DIFF_W'(iy1) - DIFF_W'(iy2);
            f1_reg <= DIFF_W'(ix3) - DIFF_W'(ix1);
            g1_reg <= DIFF_W'(iy3) - DIFF_W'(iy1);

            p1_reg  <= a1_reg * b1_reg;
            p2_reg  <= c1_reg * e1_reg;
            s1_reg  <= SQ_W'(x1_reg * x1_reg) + SQ_W'(y1_reg * y1_reg);
            s2_reg  <= SQ_W'(x2_reg * x2_reg) + SQ_W'(y2_reg * y2_reg);
            s3_reg  <= SQ_W'(x3_reg * x3_reg) + SQ_W'(y3_reg * y3_reg);
            l12_reg <= SIDE_W'(a1_reg * a1_reg) + SIDE_W'(e1_reg * e1_reg);
            l23_reg <= SIDE_W'(c1_reg * c1_reg) + SIDE_W'(b1_reg * b1_reg);
            l31_reg <= SIDE_W'(f1_reg * f1_reg) + SIDE_W'(g1_reg * g1_reg);
            a2_reg  <= a1_reg;
            b2_reg  <= b1_reg;
            c2_reg  <= c1_reg;
            e2_reg  <= e1_reg;

            det3_reg <= DET_W'(p1_reg) - DET_W'(p2_reg);
            d12_reg  <= SDIF_W'(s1_reg) - SDIF_W'(s2_reg);
            d23_reg  <= SDIF_W'(s2_reg) - SDIF_W'(s3_reg);
            pp_reg   <= l12_reg * l23_reg;
            l31b_reg <= l31_reg;
            a3_reg   <= a2_reg;
            b3_reg   <= b2_reg;
            c3_reg   <= c2_reg;
            e3_reg   <= e2_reg;

            m1_reg    <= d12_reg * b3_reg;
            m2_reg    <= d23_reg * e3_reg;
            m3_reg    <= d23_reg * a3_reg;
            m4_reg    <= d12_reg * c3_reg;
            det2_reg  <= RAD_D_W'(det_sq[RAD_D_W-3:0]) << 2;
            ph_reg    <= pp_reg[PAIR_W-1:SIDE_W] * l31b_reg;
            pl_reg    <= pp_reg[SIDE_W-1:0] * l31b_reg;
            adet4_reg <= adet_v;
            deg4_reg  <= (det3_reg == '0);
            neg4_reg  <= det3_reg[DET_W-1];

            nx_reg    <= CNUM_W'(m1_reg) - CNUM_W'(m2_reg);
            ny_reg    <= CNUM_W'(m3_reg) - CNUM_W'(m4_reg);
            num_reg   <= (TRIP_W'(ph_reg) << SIDE_W) + TRIP_W'(pl_reg);
            dsq_reg   <= det2_reg;
            adet5_reg <= adet4_reg;
            deg5_reg  <= deg4_reg;
            neg5_reg  <= neg4_reg;

            out_reg.rad.n <= RAD_N_W'(num_reg) << (2 * RADIUS_FRAC_BITS);
            out_reg.rad.r <= '0;
            out_reg.rad.d <= deg5_reg ? RAD_D_W'(1) : dsq_reg;
            out_reg.cx.n  <= RAD_N_W'(anx);
            out_reg.cx.r  <= '0;
            out_reg.cx.d  <= deg5_reg ? CEN_D_W'(1) : {adet5_reg, 1'b0};
            out_reg.cy.n  <= RAD_N_W'(any_v);
            out_reg.cy.r  <= '0;
            out_reg.cy.d  <= deg5_reg ? CEN_D_W'(1) : {adet5_reg, 1'b0};
            out_reg.sx    <= nx_reg[CNUM_W-1] ^ neg5_reg;
            out_reg.sy    <= ny_reg[CNUM_W-1] ^ neg5_reg;
            out_reg.deg   <= deg5_reg;
        end
    end

    assign out_valid = vld_reg[5];
    assign out_data  = out_reg;

endmodule

[hdl/cttp_div_cell.sv]
module cttp_div_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  cttp_pkg::div_t in_data,
    output logic           out_valid,
    output cttp_pkg::div_t out_data
);
    import cttp_pkg::*;

    logic   vld_reg;
    div_t   data_reg;
    div_t   data_next;
    logic [RAD_D_W:0] rad_sh;
    logic [CEN_D_W:0] cx_sh, cy_sh;
    logic             rad_ge, cx_ge, cy_ge;

    always_comb
    begin
        data_next = in_data;
        rad_sh = {in_data.rad.r[RAD_D_W-1:0], in_data.rad.n[RAD_N_W-1]};
        cx_sh  = {in_data.cx.r[CEN_D_W-1:0], in_data.cx.n[RAD_N_W-1]};
        cy_sh  = {in_data.cy.r[CEN_D_W-1:0], in_data.cy.n[RAD_N_W-1]};
        rad_ge = rad_sh >= {1'b0, in_data.rad.d};
        cx_ge  = cx_sh >= {1'b0, in_data.cx.d};
        cy_ge  = cy_sh >= {1'b0, in_data.cy.d};
        data_next.rad.r = rad_ge ? rad_sh - {1'b0, in_data.rad.d} : rad_sh;
        data_next.cx.r  = cx_ge ? cx_sh - {1'b0, in_data.cx.d} : cx_sh;
        data_next.cy.r  = cy_ge ? cy_sh - {1'b0, in_data.cy.d} : cy_sh;
        data_next.rad.n = {in_data.rad.n[RAD_N_W-2:0], rad_ge};
        data_next.cx.n  = {in_data.cx.n[RAD_N_W-2:0], cx_ge};
        data_next.cy.n  = {in_data.cy.n[RAD_N_W-2:0], cy_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

[hdl/cttp_sqrt_cell.sv]
module cttp_sqrt_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  cttp_pkg::sq_t in_data,
    output logic          out_valid,
    output cttp_pkg::sq_t out_data
);
    import cttp_pkg::*;

    logic vld_reg;
    sq_t  data_reg;
    sq_t  data_next;
    logic [SQ_REM_W-1:0] rem_sh;
    logic [SQ_REM_W-1:0] trial;
    logic                ge;

    always_comb
    begin
        data_next = in_data;
        rem_sh = {in_data.rem[SQ_REM_W-3:0], in_data.n[RAD_N_W-1 -: 2]};
        trial  = SQ_REM_W'({in_data.root, 2'b01});
        ge     = rem_sh >= trial;
        data_next.rem  = ge ? rem_sh - trial : rem_sh;
        data_next.root = {in_data.root[ROOT_W-2:0], ge};
        data_next.n    = {in_data.n[RAD_N_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule
